[rtl/linear_chirp_generator_unit_assert.svh]
// Assertion macros for the linear chirp generator checker.
// No dependencies; included by the checker file.
`ifndef LINEAR_CHIRP_GENERATOR_UNIT_ASSERT_SVH
`define LINEAR_CHIRP_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LCG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define LCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/lcg_pkg.sv]
// Shared constants, types and the CORDIC angle table for the chirp generator.
// No dependencies.
`default_nettype none
package lcg_pkg;

  localparam int PHASE_BITS_DEF    = 48;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int POS_BITS          = 16;
  localparam int CFG_BITS          = 48;
  localparam int SAMPLE_W          = 16;
  localparam int AMP_W             = 15;
  localparam int CORDIC_W          = 34;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032875;

  localparam logic [2:0] REG_START_STEP   = 3'd0;
  localparam logic [2:0] REG_CHIRP_RATE   = 3'd1;
  localparam logic [2:0] REG_PERIOD       = 3'd2;
  localparam logic [2:0] REG_PHASE_OFFSET = 3'd3;
  localparam logic [2:0] REG_AMPLITUDE    = 3'd4;

  typedef struct packed {
    logic [31:0] phase;
    logic        start;
  } job_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_angle(input logic [4:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12e4051e;
      5'd2:  a = 32'h09fb385b;
      5'd3:  a = 32'h051111d4;
      5'd4:  a = 32'h028b0d43;
      5'd5:  a = 32'h0145d7e1;
      5'd6:  a = 32'h00a2f61e;
      5'd7:  a = 32'h00517c55;
      5'd8:  a = 32'h0028be53;
      5'd9:  a = 32'h00145f2f;
      5'd10: a = 32'h000a2f98;
      5'd11: a = 32'h000517cc;
      5'd12: a = 32'h00028be6;
      5'd13: a = 32'h000145f3;
      5'd14: a = 32'h0000a2fa;
      5'd15: a = 32'h0000517d;
      5'd16: a = 32'h000028be;
      5'd17: a = 32'h0000145f;
      5'd18: a = 32'h00000a30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028c;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000a3;
      5'd23: a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

[rtl/lcg_front.sv]
// Front end: accepts ticks, keeps position and quadratic phase state, emits phase jobs.
// Depends on lcg_pkg.
`default_nettype none
module lcg_front #(
  parameter int PHASE_BITS = lcg_pkg::PHASE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_ready,
  input  wire logic                          restart,
  input  wire logic [lcg_pkg::CFG_BITS-1:0]  start_step,
  input  wire logic [lcg_pkg::CFG_BITS-1:0]  chirp_rate,
  input  wire logic [lcg_pkg::POS_BITS-1:0]  period_samples,
  input  wire logic [15:0]                   phase_offset,
  input  wire logic                          job_full,
  output logic                               job_push,
  output lcg_pkg::job_t                      job
);

  logic [lcg_pkg::POS_BITS-1:0] position, pos_cur;
  logic [lcg_pkg::POS_BITS:0]   pos_inc;
  logic [PHASE_BITS-1:0]        phase_acc, phase_step;
  logic [PHASE_BITS-1:0]        acc_cur, step_cur, init_step, k_trunc, off, ph;
  logic signed [63:0]           start_ext, rate_ext, init_full;
  logic [31:0]                  ph32;
  logic                         start, accept;

  assign item_ready = !job_full;
  assign accept     = item_valid && item_ready;
  assign job_push   = accept;

  always_comb begin
    start_ext = 64'(signed'(start_step));
    rate_ext  = 64'(signed'(chirp_rate));
    init_full = start_ext + (rate_ext >>> 1);
    init_step = init_full[PHASE_BITS-1:0];
    k_trunc   = rate_ext[PHASE_BITS-1:0];
    pos_cur   = restart ? '0 : position;
    start     = (pos_cur == '0);
    acc_cur   = start ? '0 : phase_acc;
    step_cur  = start ? init_step : phase_step;
    off       = {phase_offset, {(PHASE_BITS-16){1'b0}}};
    ph        = acc_cur + off;
    pos_inc   = {1'b0, pos_cur} + 1'b1;
  end

  if (PHASE_BITS >= 32) begin : g_wide
    assign ph32 = ph[PHASE_BITS-1 -: 32];
  end else begin : g_narrow
    assign ph32 = {ph, {(32-PHASE_BITS){1'b0}}};
  end

  assign job.phase = ph32;
  assign job.start = start;

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      phase_acc  <= '0;
      phase_step <= '0;
    end else if (accept) begin
      phase_acc  <= acc_cur + step_cur;
      phase_step <= step_cur + k_trunc;
      if (pos_inc >= {1'b0, period_samples}) begin
        position <= '0;
      end else begin
        position <= pos_inc[lcg_pkg::POS_BITS-1:0];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/lcg_queue.sv]
// Small job queue between the front end and the CORDIC back end.
// Depends on lcg_pkg.
`default_nettype none
module lcg_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lcg_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output lcg_pkg::job_t      pop_job,
  output logic               empty
);

  localparam int PW = $clog2(lcg_pkg::QUEUE_DEPTH);

  lcg_pkg::job_t  mem [lcg_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [PW:0]    count;
  logic           do_push, do_pop;

  assign full    = (count == (PW+1)'(lcg_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/lcg_back.sv]
// Back end: iterative CORDIC sine, rounding, clamp, amplitude scaling, output register.
// Depends on lcg_pkg.
`default_nettype none
module lcg_back #(
  parameter int CORDIC_STAGES = lcg_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          job_empty,
  input  wire lcg_pkg::job_t                 job,
  output logic                               job_pop,
  input  wire logic [lcg_pkg::AMP_W-1:0]     amplitude,
  output logic                               sample_valid,
  input  wire logic                          sample_ready,
  output logic signed [lcg_pkg::SAMPLE_W-1:0] sample,
  output logic                               period_start
);

  localparam int W  = lcg_pkg::CORDIC_W;
  localparam int IW = $clog2(CORDIC_STAGES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ROT  = 4'b0010,
    S_RND  = 4'b0100,
    S_MUL  = 4'b1000
  } state_t;

  localparam logic signed [32:0] QTR_TURN  = 33'sd1073741824;
  localparam logic signed [32:0] HALF_TURN = 33'sd2147483648;
  localparam logic signed [W-1:0] RND_BIAS = 34'sd16384;
  localparam logic signed [W-1:0] SIN_MAX  = 34'sd32767;

  state_t                 state;
  logic [IW-1:0]          iter;
  logic signed [W-1:0]    x, y, z, dx, dy, ang, yf, yt, ysh;
  logic signed [32:0]     a, afold;
  logic                   neg, negf, start_q, out_load;
  logic signed [lcg_pkg::SAMPLE_W-1:0] r;
  logic signed [lcg_pkg::SAMPLE_W-1:0] amp_s;
  logic signed [31:0]     prod;

  assign job_pop  = (state == S_IDLE) && !job_empty;
  assign out_load = (state == S_MUL) && (!sample_valid || sample_ready);

  always_comb begin
    a     = signed'({job.phase[31], job.phase});
    negf  = (a > QTR_TURN) || (a < -QTR_TURN);
    if (a > QTR_TURN) begin
      afold = a - HALF_TURN;
    end else if (a < -QTR_TURN) begin
      afold = a + HALF_TURN;
    end else begin
      afold = a;
    end
    dx    = y >>> iter;
    dy    = x >>> iter;
    ang   = signed'({2'b00, lcg_pkg::atan_angle(5'(iter))});
    yf    = neg ? -y : y;
    yt    = yf + RND_BIAS;
    ysh   = yt >>> 15;
    amp_s = signed'({1'b0, amplitude});
    prod  = amp_s * r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      iter         <= '0;
      sample_valid <= 1'b0;
    end else begin
      if (out_load) begin
        sample_valid <= 1'b1;
      end else if (sample_ready) begin
        sample_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!job_empty) begin
            state <= S_ROT;
            iter  <= '0;
          end
        end
        S_ROT: begin
          iter <= iter + 1'b1;
          if (iter == IW'(CORDIC_STAGES - 1)) begin
            state <= S_RND;
          end
        end
        S_RND: begin
          state <= S_MUL;
        end
        S_MUL: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      x       <= lcg_pkg::CORDIC_GAIN_Q30;
      y       <= '0;
      z       <= W'(afold);
      neg     <= negf;
      start_q <= job.start;
    end else if (state == S_ROT) begin
      if (!z[W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - ang;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + ang;
      end
    end
    if (state == S_RND) begin
      if (ysh > SIN_MAX) begin
        r <= SIN_MAX[lcg_pkg::SAMPLE_W-1:0];
      end else if (ysh < -SIN_MAX) begin
        r <= -SIN_MAX[lcg_pkg::SAMPLE_W-1:0];
      end else begin
        r <= ysh[lcg_pkg::SAMPLE_W-1:0];
      end
    end
    if (out_load) begin
      sample       <= prod[30:15];
      period_start <= start_q;
    end
  end

endmodule
`default_nettype wire

[rtl/linear_chirp_generator_unit.sv]
// Top level of the linear chirp generator: register port, front end, queue, back end.
// Depends on lcg_pkg, lcg_front, lcg_queue, lcg_back.
//
//  port group      kind          transfer when
//  item_*/restart  input ticks   item_valid & item_ready
//  sample_*        samples       sample_valid & sample_ready
//  p* (APB)        registers     psel & penable & pwrite (pready tied high)
//
// In the back end a sample passes through load, one CORDIC rotation per cycle,
// round and clamp, and scale; the shared CORDIC sets the rate.
// The front end takes a tick whenever the two-entry queue has room.
// A waiting output stalls only the back end; the front keeps filling the queue.
// Synchronous reset clears position, phase state and the configuration registers to defaults.
`default_nettype none
module linear_chirp_generator_unit #(
  parameter int PHASE_BITS    = lcg_pkg::PHASE_BITS_DEF,
  parameter int CORDIC_STAGES = lcg_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_ready,
  input  wire logic                            restart,
  output logic                                 sample_valid,
  input  wire logic                            sample_ready,
  output logic signed [lcg_pkg::SAMPLE_W-1:0]  sample,
  output logic                                 period_start,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [5:0]                      paddr,
  input  wire logic [63:0]                     pwdata,
  output logic [63:0]                          prdata,
  output logic                                 pready
);

  logic [lcg_pkg::CFG_BITS-1:0] start_step, chirp_rate;
  logic [lcg_pkg::POS_BITS-1:0] period_samples;
  logic [15:0]                  phase_offset;
  logic [lcg_pkg::AMP_W-1:0]    amplitude;
  logic [2:0]                   reg_idx;
  logic                         wr_en;
  logic                         job_full, job_push, job_pop, job_empty;
  lcg_pkg::job_t                push_job, pop_job;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_step     <= '0;
      chirp_rate     <= '0;
      period_samples <= 16'd1024;
      phase_offset   <= '0;
      amplitude      <= 15'd32767;
    end else if (wr_en) begin
      unique case (reg_idx)
        lcg_pkg::REG_START_STEP:   start_step     <= pwdata[lcg_pkg::CFG_BITS-1:0];
        lcg_pkg::REG_CHIRP_RATE:   chirp_rate     <= pwdata[lcg_pkg::CFG_BITS-1:0];
        lcg_pkg::REG_PERIOD:       period_samples <= pwdata[lcg_pkg::POS_BITS-1:0];
        lcg_pkg::REG_PHASE_OFFSET: phase_offset   <= pwdata[15:0];
        lcg_pkg::REG_AMPLITUDE:    amplitude      <= pwdata[lcg_pkg::AMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lcg_pkg::REG_START_STEP:   prdata = 64'(start_step);
      lcg_pkg::REG_CHIRP_RATE:   prdata = 64'(chirp_rate);
      lcg_pkg::REG_PERIOD:       prdata = 64'(period_samples);
      lcg_pkg::REG_PHASE_OFFSET: prdata = 64'(phase_offset);
      lcg_pkg::REG_AMPLITUDE:    prdata = 64'(amplitude);
      default:                   prdata = '0;
    endcase
  end

  lcg_front #(
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .restart       (restart),
    .start_step    (start_step),
    .chirp_rate    (chirp_rate),
    .period_samples(period_samples),
    .phase_offset  (phase_offset),
    .job_full      (job_full),
    .job_push      (job_push),
    .job           (push_job)
  );

  lcg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .push_job(push_job),
    .full    (job_full),
    .pop     (job_pop),
    .pop_job (pop_job),
    .empty   (job_empty)
  );

  lcg_back #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_empty   (job_empty),
    .job         (pop_job),
    .job_pop     (job_pop),
    .amplitude   (amplitude),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample      (sample),
    .period_start(period_start)
  );

endmodule
`default_nettype wire

[rtl/lcg_checker.sv]
// Port-level checks for the chirp generator, bound to the top level.
// Depends on linear_chirp_generator_unit_assert.svh.
`default_nettype none
`include "linear_chirp_generator_unit_assert.svh"
module lcg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        sample_valid,
  input wire logic        sample_ready,
  input wire logic [15:0] sample,
  input wire logic        period_start,
  input wire logic        pready
);

  logic stall;

  assign stall = sample_valid && !sample_ready;

  // clamped sine times a 15-bit amplitude never reaches the negative end
  `LCG_ASSERT_NOW(a_sample_range, sample_valid, sample != 16'h8000, "sample out of range")

  `LCG_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")

  `LCG_ASSERT_NEXT(a_out_hold, stall, sample_valid, "stalled sample dropped")

  `LCG_ASSERT_NEXT(a_data_hold, stall, $stable({sample, period_start}), "stalled sample changed")

endmodule

bind linear_chirp_generator_unit lcg_checker u_lcg_checker (
  .clk         (clk),
  .rst         (rst),
  .sample_valid(sample_valid),
  .sample_ready(sample_ready),
  .sample      (sample),
  .period_start(period_start),
  .pready      (pready)
);
`default_nettype wire
